>>> src/sbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_pkg: shared types and constants of the branch execute stage
// Item structs for both channels, opcode codes, status codes and limits.
// ----------------------------------------------------------------------------
package sbe_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_JUMP  = 2'd1,
    STATUS_POP_FAULT = 2'd2
  } status_e;

  // condition codes in opcode bits 4:3
  typedef enum logic [1:0] {
    COND_NZ = 2'd0,
    COND_Z  = 2'd1,
    COND_NC = 2'd2,
    COND_C  = 2'd3
  } cond_e;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_JR,
    KIND_JP,
    KIND_JP_HL,
    KIND_CALL,
    KIND_RST,
    KIND_RET,
    KIND_RETI
  } kind_e;

  localparam logic [7:0] OP_JR      = 8'h18;
  localparam logic [7:0] OP_JP      = 8'hC3;
  localparam logic [7:0] OP_JP_HL   = 8'hE9;
  localparam logic [7:0] OP_CALL    = 8'hCD;
  localparam logic [7:0] OP_RET     = 8'hC9;
  localparam logic [7:0] OP_RETI    = 8'hD9;

  // conditional forms: opcode with bits 4:3 masked off
  localparam logic [7:0] CC_MASK    = 8'hE7;
  localparam logic [7:0] OP_JR_CC   = 8'h20;
  localparam logic [7:0] OP_JP_CC   = 8'hC2;
  localparam logic [7:0] OP_CALL_CC = 8'hC4;
  localparam logic [7:0] OP_RET_CC  = 8'hC0;

  localparam logic [7:0] RST_MASK   = 8'hC7;
  localparam logic [7:0] RST_VECTOR = 8'h38;

  localparam logic [15:0] POP_LIMIT = 16'hFFFE;
  localparam logic [15:0] SP_STEP   = 16'd2;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] pc;
    logic [15:0] sp;
    logic [15:0] hl;
    logic [15:0] immediate;
    logic        zero_flag;
    logic        carry_flag;
    logic [15:0] stack_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [15:0] next_sp;
    logic        taken;
    logic        push_valid;
    logic [15:0] push_address;
    logic [15:0] push_word;
    logic        pop_used;
    logic        interrupt_enable;
    status_e     status;
  } out_item_t;

endpackage

>>> src/sm83_branch_execute.sv
`timescale 1ns / 1ps
// Pipeline: each instruction passes the input register and then the result register.
// Throughput: one instruction per cycle while the sink is ready; the decode and 16-bit adds sit
//   between the two registers, and each register accepts while its held item transfers out.
// Reset: rst_ni clears both valid flags asynchronously; the data registers are not reset.
// ----------------------------------------------------------------------------
// sm83_branch_execute: control-transfer execute stage
// JR, JP, CALL, RET, RETI and RST with conditions, push and pop requests.
// ----------------------------------------------------------------------------
module sm83_branch_execute (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sbe_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sbe_pkg::out_item_t out_data_o
);

  logic               in_q_valid;
  logic               res_ready;
  sbe_pkg::in_item_t  in_q;
  sbe_pkg::out_item_t result;

  sbe_stage #(
    .item_t(sbe_pkg::in_item_t)
  ) u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .ready_o(in_ready_o),
    .data_i (in_data_i),
    .valid_o(in_q_valid),
    .ready_i(res_ready),
    .data_o (in_q)
  );

  sbe_exec u_exec (
    .item_i  (in_q),
    .result_o(result)
  );

  sbe_stage #(
    .item_t(sbe_pkg::out_item_t)
  ) u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_q_valid),
    .ready_o(res_ready),
    .data_i (result),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_data_o)
  );

endmodule

>>> src/sbe_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_stage: valid/ready pipeline register
// Holds one item; loads a new one in the same cycle the held one transfers.
// ----------------------------------------------------------------------------
module sbe_stage #(
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t data_o
);

  logic  valid_q, valid_d;
  item_t data_q;
  logic  load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> src/sbe_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_exec: control-transfer decode and execute
// Decodes the opcode, resolves the condition and forms PC, SP and push data.
// ----------------------------------------------------------------------------
module sbe_exec (
  input  sbe_pkg::in_item_t  item_i,
  output sbe_pkg::out_item_t result_o
);

  sbe_pkg::kind_e kind;
  logic           is_cond;
  logic           cond_ok;
  logic           go;
  logic [7:0]     op;
  logic [15:0]    jr_offset;
  logic [15:0]    sp_dec;
  logic [15:0]    sp_inc;

  assign op = item_i.opcode;

  always_comb begin
    is_cond = 1'b0;
    kind    = sbe_pkg::KIND_NONE;
    if (op == sbe_pkg::OP_JR) begin
      kind = sbe_pkg::KIND_JR;
    end else if ((op & sbe_pkg::CC_MASK) == sbe_pkg::OP_JR_CC) begin
      kind    = sbe_pkg::KIND_JR;
      is_cond = 1'b1;
    end else if (op == sbe_pkg::OP_JP) begin
      kind = sbe_pkg::KIND_JP;
    end else if ((op & sbe_pkg::CC_MASK) == sbe_pkg::OP_JP_CC) begin
      kind    = sbe_pkg::KIND_JP;
      is_cond = 1'b1;
    end else if (op == sbe_pkg::OP_JP_HL) begin
      kind = sbe_pkg::KIND_JP_HL;
    end else if (op == sbe_pkg::OP_CALL) begin
      kind = sbe_pkg::KIND_CALL;
    end else if ((op & sbe_pkg::CC_MASK) == sbe_pkg::OP_CALL_CC) begin
      kind    = sbe_pkg::KIND_CALL;
      is_cond = 1'b1;
    end else if (op == sbe_pkg::OP_RET) begin
      kind = sbe_pkg::KIND_RET;
    end else if ((op & sbe_pkg::CC_MASK) == sbe_pkg::OP_RET_CC) begin
      kind    = sbe_pkg::KIND_RET;
      is_cond = 1'b1;
    end else if (op == sbe_pkg::OP_RETI) begin
      kind = sbe_pkg::KIND_RETI;
    end else if ((op & sbe_pkg::RST_MASK) == sbe_pkg::RST_MASK) begin
      kind = sbe_pkg::KIND_RST;
    end
  end

  always_comb begin
    case (sbe_pkg::cond_e'(op[4:3]))
      sbe_pkg::COND_NZ: cond_ok = !item_i.zero_flag;
      sbe_pkg::COND_Z:  cond_ok = item_i.zero_flag;
      sbe_pkg::COND_NC: cond_ok = !item_i.carry_flag;
      sbe_pkg::COND_C:  cond_ok = item_i.carry_flag;
      default:          cond_ok = 1'b0;
    endcase
  end

  assign go        = (kind != sbe_pkg::KIND_NONE) && (!is_cond || cond_ok);
  assign jr_offset = {{8{item_i.immediate[7]}}, item_i.immediate[7:0]};
  assign sp_dec    = item_i.sp - sbe_pkg::SP_STEP;
  assign sp_inc    = item_i.sp + sbe_pkg::SP_STEP;

  always_comb begin
    result_o                  = '0;
    result_o.next_pc          = item_i.pc;
    result_o.next_sp          = item_i.sp;
    result_o.status           = sbe_pkg::STATUS_OK;
    if (kind == sbe_pkg::KIND_NONE) begin
      result_o.status = sbe_pkg::STATUS_NOT_JUMP;
    end else if (go) begin
      case (kind)
        sbe_pkg::KIND_JR: begin
          result_o.next_pc = item_i.pc + jr_offset;
          result_o.taken   = 1'b1;
        end
        sbe_pkg::KIND_JP: begin
          result_o.next_pc = item_i.immediate;
          result_o.taken   = 1'b1;
        end
        sbe_pkg::KIND_JP_HL: begin
          result_o.next_pc = item_i.hl;
          result_o.taken   = 1'b1;
        end
        sbe_pkg::KIND_CALL, sbe_pkg::KIND_RST: begin
          result_o.next_sp      = sp_dec;
          result_o.push_valid   = 1'b1;
          result_o.push_address = sp_dec;
          result_o.push_word    = item_i.pc;
          result_o.next_pc      = (kind == sbe_pkg::KIND_CALL) ? item_i.immediate
                                  : {8'h00, op & sbe_pkg::RST_VECTOR};
          result_o.taken        = 1'b1;
        end
        sbe_pkg::KIND_RET, sbe_pkg::KIND_RETI: begin
          // pop only when SP+2 stays inside the address space
          if (item_i.sp >= sbe_pkg::POP_LIMIT) begin
            result_o.status = sbe_pkg::STATUS_POP_FAULT;
          end else begin
            result_o.next_pc          = item_i.stack_word;
            result_o.next_sp          = sp_inc;
            result_o.pop_used         = 1'b1;
            result_o.interrupt_enable = (kind == sbe_pkg::KIND_RETI);
            result_o.taken            = 1'b1;
          end
        end
        default: begin
          result_o.status = sbe_pkg::STATUS_NOT_JUMP;
        end
      endcase
    end
  end

endmodule

>>> src/sbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_checker: port-level checks of the branch execute stage
// Output channel hold rules, result consistency and pipeline latency.
// ----------------------------------------------------------------------------
module sbe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sbe_pkg::out_item_t out_data_o
);

  // stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // a push always targets the new stack pointer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.push_valid |->
      out_data_o.push_address == out_data_o.next_sp && out_data_o.taken)
    else $error("push address differs from next SP");

  // no transfer, no side effects
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.taken |->
      !out_data_o.push_valid && !out_data_o.pop_used && !out_data_o.interrupt_enable)
    else $error("strobe raised on untaken instruction");

  // with the sink ready, a transfer shows up once it has passed the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("result missing after two cycles");

endmodule

bind sm83_branch_execute sbe_checker u_sbe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

>>> tb/sm83_branch_execute_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_branch_execute_test: self-checking bench for the branch execute stage
// Drives JR/JP/CALL/RET/RETI/RST instructions through the valid/ready input,
// predicts each result in a local model and checks every output transfer
// against the oldest pending prediction, under random idling and backpressure.
// ----------------------------------------------------------------------------
module sm83_branch_execute_test;

  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam logic [7:0]  OP_NOP        = 8'h00;
  localparam logic [7:0]  OP_HALT       = 8'h76;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  sbe_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  sbe_pkg::out_item_t out_data_o;

  sbe_pkg::out_item_t expected_results[$];
  int         error_count    = 0;
  int         cycle_count    = 0;
  int         instr_sent     = 0;
  int         results_seen   = 0;
  int         taken_seen     = 0;
  int         fault_seen     = 0;
  int         not_jump_seen  = 0;
  int         hold_cycles    = 0;
  bit         send_idle_en   = 1'b0;
  bit         sink_idle_en   = 1'b0;

  sm83_branch_execute DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Local model of the execute stage
  // --------------------------------------------------------------------------
  function automatic sbe_pkg::out_item_t predict_branch(input sbe_pkg::in_item_t it);
    sbe_pkg::out_item_t r;
    sbe_pkg::kind_e     kind;
    logic               is_cond;
    logic               cond_ok;
    r          = '0;
    r.next_pc  = it.pc;
    r.next_sp  = it.sp;
    r.status   = sbe_pkg::STATUS_OK;
    is_cond    = 1'b0;
    kind       = sbe_pkg::KIND_NONE;
    if (it.opcode == sbe_pkg::OP_JR) kind = sbe_pkg::KIND_JR;
    else if (it.opcode == sbe_pkg::OP_JP) kind = sbe_pkg::KIND_JP;
    else if (it.opcode == sbe_pkg::OP_JP_HL) kind = sbe_pkg::KIND_JP_HL;
    else if (it.opcode == sbe_pkg::OP_CALL) kind = sbe_pkg::KIND_CALL;
    else if (it.opcode == sbe_pkg::OP_RET) kind = sbe_pkg::KIND_RET;
    else if (it.opcode == sbe_pkg::OP_RETI) kind = sbe_pkg::KIND_RETI;
    else if ((it.opcode & sbe_pkg::CC_MASK) == sbe_pkg::OP_JR_CC) begin
      kind = sbe_pkg::KIND_JR;
      is_cond = 1'b1;
    end else if ((it.opcode & sbe_pkg::CC_MASK) == sbe_pkg::OP_JP_CC) begin
      kind = sbe_pkg::KIND_JP;
      is_cond = 1'b1;
    end else if ((it.opcode & sbe_pkg::CC_MASK) == sbe_pkg::OP_CALL_CC) begin
      kind = sbe_pkg::KIND_CALL;
      is_cond = 1'b1;
    end else if ((it.opcode & sbe_pkg::CC_MASK) == sbe_pkg::OP_RET_CC) begin
      kind = sbe_pkg::KIND_RET;
      is_cond = 1'b1;
    end else if ((it.opcode & sbe_pkg::RST_MASK) == sbe_pkg::RST_MASK) begin
      kind = sbe_pkg::KIND_RST;
    end

    case (sbe_pkg::cond_e'(it.opcode[4:3]))
      sbe_pkg::COND_NZ: cond_ok = !it.zero_flag;
      sbe_pkg::COND_Z:  cond_ok = it.zero_flag;
      sbe_pkg::COND_NC: cond_ok = !it.carry_flag;
      default:          cond_ok = it.carry_flag;
    endcase

    if (kind == sbe_pkg::KIND_NONE) begin
      r.status = sbe_pkg::STATUS_NOT_JUMP;
    end else if (!is_cond || cond_ok) begin
      case (kind)
        sbe_pkg::KIND_JR: begin
          r.next_pc = it.pc + {{8{it.immediate[7]}}, it.immediate[7:0]};
          r.taken   = 1'b1;
        end
        sbe_pkg::KIND_JP: begin
          r.next_pc = it.immediate;
          r.taken   = 1'b1;
        end
        sbe_pkg::KIND_JP_HL: begin
          r.next_pc = it.hl;
          r.taken   = 1'b1;
        end
        sbe_pkg::KIND_CALL, sbe_pkg::KIND_RST: begin
          r.next_sp      = it.sp - sbe_pkg::SP_STEP;
          r.push_valid   = 1'b1;
          r.push_address = it.sp - sbe_pkg::SP_STEP;
          r.push_word    = it.pc;
          r.next_pc      = (kind == sbe_pkg::KIND_CALL) ? it.immediate
                           : {8'h00, it.opcode & sbe_pkg::RST_VECTOR};
          r.taken        = 1'b1;
        end
        default: begin
          // returns only fault when they would really pop
          if (it.sp >= sbe_pkg::POP_LIMIT) begin
            r.status = sbe_pkg::STATUS_POP_FAULT;
          end else begin
            r.next_pc          = it.stack_word;
            r.next_sp          = it.sp + sbe_pkg::SP_STEP;
            r.pop_used         = 1'b1;
            r.interrupt_enable = (kind == sbe_pkg::KIND_RETI);
            r.taken            = 1'b1;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic sbe_pkg::in_item_t make_instr(input logic [7:0] op,
                                                   input logic [15:0] pc,
                                                   input logic [15:0] sp,
                                                   input logic [15:0] hl,
                                                   input logic [15:0] imm, input logic z,
                                                   input logic c, input logic [15:0] sw);
    sbe_pkg::in_item_t it;
    it.opcode     = op;
    it.pc         = pc;
    it.sp         = sp;
    it.hl         = hl;
    it.immediate  = imm;
    it.zero_flag  = z;
    it.carry_flag = c;
    it.stack_word = sw;
    return it;
  endfunction

  function automatic logic [7:0] cc_op(input logic [7:0] base, input sbe_pkg::cond_e cc);
    return base | {3'b000, cc, 3'b000};
  endfunction

  function automatic sbe_pkg::in_item_t random_instr();
    sbe_pkg::in_item_t it;
    it.pc         = 16'($urandom);
    it.hl         = 16'($urandom);
    it.immediate  = 16'($urandom);
    it.zero_flag  = 1'($urandom);
    it.carry_flag = 1'($urandom);
    it.stack_word = 16'($urandom);
    case ($urandom_range(0, 11))
      0:       it.opcode = sbe_pkg::OP_JR;
      1:       it.opcode = sbe_pkg::OP_JR_CC | (8'($urandom) & ~sbe_pkg::CC_MASK);
      2:       it.opcode = sbe_pkg::OP_JP;
      3:       it.opcode = sbe_pkg::OP_JP_CC | (8'($urandom) & ~sbe_pkg::CC_MASK);
      4:       it.opcode = sbe_pkg::OP_JP_HL;
      5:       it.opcode = sbe_pkg::OP_CALL;
      6:       it.opcode = sbe_pkg::OP_CALL_CC | (8'($urandom) & ~sbe_pkg::CC_MASK);
      7:       it.opcode = sbe_pkg::OP_RET;
      8:       it.opcode = sbe_pkg::OP_RET_CC | (8'($urandom) & ~sbe_pkg::CC_MASK);
      9:       it.opcode = sbe_pkg::OP_RETI;
      10:      it.opcode = sbe_pkg::RST_MASK | (8'($urandom) & sbe_pkg::RST_VECTOR);
      default: it.opcode = 8'($urandom);
    endcase
    // bias SP toward the pop limit and the push wrap
    case ($urandom_range(0, 7))
      0:       it.sp = sbe_pkg::POP_LIMIT + 16'($urandom_range(0, 1));
      1:       it.sp = 16'($urandom_range(0, 3));
      2:       it.sp = sbe_pkg::POP_LIMIT - 16'd1;
      default: it.sp = 16'($urandom);
    endcase
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus side
  // --------------------------------------------------------------------------
  // Valid stays high after a transfer so back-to-back items need no gap;
  // it only drops for an idle burst or through stop_sending.
  task automatic send_instr(input sbe_pkg::in_item_t it);
    int gap;
    @(negedge clk_i);
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_branch(it));
    instr_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // result sink: random stall bursts plus an occasional long hold
  initial begin : result_sink
    int n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 19);
        out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking side
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string field, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%04h want 0x%04h", field, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    sbe_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with no pending instruction");
      end else begin
        want = expected_results.pop_front();
        check_field("next_pc", out_data_o.next_pc, want.next_pc);
        check_field("next_sp", out_data_o.next_sp, want.next_sp);
        check_field("taken", 16'(out_data_o.taken), 16'(want.taken));
        check_field("push_valid", 16'(out_data_o.push_valid), 16'(want.push_valid));
        check_field("push_address", out_data_o.push_address, want.push_address);
        check_field("push_word", out_data_o.push_word, want.push_word);
        check_field("pop_used", 16'(out_data_o.pop_used), 16'(want.pop_used));
        check_field("interrupt_enable", 16'(out_data_o.interrupt_enable),
                    16'(want.interrupt_enable));
        check_field("status", 16'(out_data_o.status), 16'(want.status));
        results_seen++;
        if (want.taken) taken_seen++;
        if (want.status == sbe_pkg::STATUS_POP_FAULT) fault_seen++;
        if (want.status == sbe_pkg::STATUS_NOT_JUMP) not_jump_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_relative_jumps();
    // offset +127 wrapping past 0xFFFF, then -128 wrapping below zero
    send_instr(make_instr(sbe_pkg::OP_JR, 16'hFFF0, 16'h8000, 16'h0, 16'h007F,
                          1'b0, 1'b0, 16'h0));
    send_instr(make_instr(sbe_pkg::OP_JR, 16'h0010, 16'h8000, 16'h0, 16'hAB80,
                          1'b1, 1'b1, 16'h0));
    send_instr(make_instr(cc_op(sbe_pkg::OP_JR_CC, sbe_pkg::COND_NZ), 16'h4000, 16'h1000,
                          16'h0, 16'h0005, 1'b0, 1'b0, 16'h0));
    send_instr(make_instr(cc_op(sbe_pkg::OP_JR_CC, sbe_pkg::COND_Z), 16'h4000, 16'h1000,
                          16'h0, 16'h00FF, 1'b0, 1'b1, 16'h0));
  endtask

  task automatic test_absolute_jumps();
    send_instr(make_instr(sbe_pkg::OP_JP, 16'h0000, 16'h0000, 16'h0, 16'hFFFF,
                          1'b0, 1'b0, 16'h0));
    send_instr(make_instr(cc_op(sbe_pkg::OP_JP_CC, sbe_pkg::COND_NC), 16'h1234, 16'hC000,
                          16'h0, 16'h5555, 1'b0, 1'b1, 16'h0));
    send_instr(make_instr(cc_op(sbe_pkg::OP_JP_CC, sbe_pkg::COND_C), 16'h1234, 16'hC000,
                          16'h0, 16'h0000, 1'b0, 1'b1, 16'h0));
    send_instr(make_instr(sbe_pkg::OP_JP_HL, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                          1'b1, 1'b1, 16'hFFFF));
  endtask

  task automatic test_calls_and_rst();
    // SP of 0 and 1 wrap the push address
    send_instr(make_instr(sbe_pkg::OP_CALL, 16'h1234, 16'h0000, 16'h0, 16'hBEEF,
                          1'b0, 1'b0, 16'h0));
    send_instr(make_instr(sbe_pkg::OP_CALL, 16'hFFFF, 16'h0001, 16'h0, 16'h0000,
                          1'b0, 1'b0, 16'h0));
    send_instr(make_instr(cc_op(sbe_pkg::OP_CALL_CC, sbe_pkg::COND_Z), 16'h0100, 16'hDFFE,
                          16'h0, 16'h2000, 1'b1, 1'b0, 16'h0));
    send_instr(make_instr(cc_op(sbe_pkg::OP_CALL_CC, sbe_pkg::COND_NZ), 16'h0100, 16'hDFFE,
                          16'h0, 16'h2000, 1'b1, 1'b0, 16'h0));
    send_instr(make_instr(sbe_pkg::RST_MASK, 16'hABCD, 16'hFFFF, 16'h0, 16'h0,
                          1'b0, 1'b0, 16'h0));
    send_instr(make_instr(sbe_pkg::RST_MASK | sbe_pkg::RST_VECTOR, 16'h0002, 16'h8000,
                          16'h0, 16'hFFFF, 1'b1, 1'b1, 16'h0));
  endtask

  task automatic test_returns();
    send_instr(make_instr(sbe_pkg::OP_RET, 16'h1000, 16'hFFFD, 16'h0, 16'h0,
                          1'b0, 1'b0, 16'hFFFF));
    // pop fault at and above the limit, RETI included
    send_instr(make_instr(sbe_pkg::OP_RET, 16'h1000, 16'hFFFE, 16'h0, 16'h0,
                          1'b0, 1'b0, 16'h1111));
    send_instr(make_instr(sbe_pkg::OP_RET, 16'h1000, 16'hFFFF, 16'h0, 16'h0,
                          1'b1, 1'b1, 16'h2222));
    send_instr(make_instr(sbe_pkg::OP_RETI, 16'h2000, 16'hFFFE, 16'h0, 16'h0,
                          1'b0, 1'b0, 16'h3333));
    send_instr(make_instr(sbe_pkg::OP_RETI, 16'h2000, 16'h0000, 16'h0, 16'h0,
                          1'b0, 1'b0, 16'h0000));
    // failing condition never checks the pop limit
    send_instr(make_instr(cc_op(sbe_pkg::OP_RET_CC, sbe_pkg::COND_C), 16'h3000, 16'hFFFF,
                          16'h0, 16'h0, 1'b0, 1'b0, 16'h4444));
    send_instr(make_instr(cc_op(sbe_pkg::OP_RET_CC, sbe_pkg::COND_NC), 16'h3000, 16'h1000,
                          16'h0, 16'h0, 1'b0, 1'b0, 16'h5555));
  endtask

  task automatic test_non_jump();
    send_instr(make_instr(OP_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                          16'hFFFF));
    send_instr(make_instr(OP_HALT, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0));
  endtask

  task automatic test_random_mix(input int count);
    send_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    repeat (count) send_instr(random_instr());
  endtask

  task automatic test_output_hold(input int count);
    // sink stalls for a long stretch while the sender keeps offering
    send_idle_en = 1'b0;
    hold_cycles  = HOLD_CYCLES;
    repeat (count) send_instr(random_instr());
  endtask

  task automatic test_drain_pause(input int count);
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk_i);
    send_idle_en = 1'b1;
    repeat (count) send_instr(random_instr());
  endtask

  task automatic test_random_no_idle(input int count);
    send_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (count) send_instr(random_instr());
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_relative_jumps();
    test_absolute_jumps();
    test_calls_and_rst();
    test_returns();
    test_non_jump();
    test_random_mix(1000);
    test_output_hold(40);
    test_drain_pause(100);
    test_random_no_idle(600);

    stop_sending();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("sent %0d instructions, checked %0d results: %0d taken, %0d pop faults, %0d non-jump",
             instr_sent, results_seen, taken_seen, fault_seen, not_jump_seen);
    $display("covered idle bursts on both sides, a %0d-cycle output hold and a drain pause",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/sbe_pkg.sv
src/sbe_stage.sv
src/sbe_exec.sv
src/sm83_branch_execute.sv
src/sbe_checker.sv
tb/sm83_branch_execute_test.sv
